>>> hw/rtl/hscr_pkg.sv
// hscr_pkg: shared types, band codes, register indexes and fixed constants
// for the height/slope color ramp. No dependencies.

package hscr_pkg;

    // Field and datapath widths
    localparam int HEIGHT_W    = 16;
    localparam int SLOPE_W     = 9;
    localparam int IN_TDATA_W  = 32;
    localparam int ABOVE_W     = 17;   // height minus sea level
    localparam int REDGE_W     = 19;   // grass-to-rock start in 1/256 m
    localparam int RDIFF_W     = 26;   // above*256 minus the grass-to-rock start
    localparam int RNUM_W      = 17;   // position inside the grass-to-rock band
    localparam int X_W         = 23;   // scaled numerator fed to the divider
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 31;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int FRAC_W      = 16;   // t, t2 and the blend weight
    localparam int KFAC_W      = 18;   // 3 - 2t in Q2.16
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_COLORS  = 6;
    localparam int PAL_IDX_W   = 3;

    // Band edges in meters above sea level
    localparam logic signed [ABOVE_W-1:0] EDGE_DEEP   = -17'sd200;
    localparam logic signed [ABOVE_W-1:0] EDGE_SEA    = 17'sd0;
    localparam logic signed [ABOVE_W-1:0] EDGE_SAND   = 17'sd200;
    localparam logic signed [ABOVE_W-1:0] EDGE_GRASS  = 17'sd400;
    localparam logic signed [ABOVE_W-1:0] EDGE_ROCK   = 17'sd4000;
    localparam logic signed [ABOVE_W-1:0] EDGE_SNOW   = 17'sd4500;

    // Grass-to-rock band, in 1/256 m: start = 1500*256 - slope*500, width 300 m
    localparam int GRASS_ROCK_BASE_256 = 384000;
    localparam int SLOPE_GAIN          = 500;
    localparam logic signed [RDIFF_W-1:0] GRASS_ROCK_SPAN_256 = 26'sd76800;

    // t = (num << shift) / d: 65536/200 = 8192/25, 65536/500 = 16384/125,
    // and 65536/76800 = 64/75
    localparam int SHIFT_WATER = 13;
    localparam int SHIFT_ROCK  = 6;
    localparam int SHIFT_SNOW  = 14;

    // 3.0 in Q2.16
    localparam logic [KFAC_W-1:0] SMOOTH_THREE = 18'd196608;

    // Palette slots
    localparam logic [PAL_IDX_W-1:0] PAL_DEEP    = 3'd0;
    localparam logic [PAL_IDX_W-1:0] PAL_SHALLOW = 3'd1;
    localparam logic [PAL_IDX_W-1:0] PAL_SAND    = 3'd2;
    localparam logic [PAL_IDX_W-1:0] PAL_GRASS   = 3'd3;
    localparam logic [PAL_IDX_W-1:0] PAL_ROCK    = 3'd4;
    localparam logic [PAL_IDX_W-1:0] PAL_SNOW    = 3'd5;

    localparam logic [23:0] COLOR_RESET [NUM_COLORS] = '{
        24'h102A60, 24'h2A6AA0, 24'hC8B478, 24'h3C7828, 24'h6E6460, 24'hF0F0F5
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEA_LEVEL     = 3'd0,
        REG_DEEP_COLOR    = 3'd1,
        REG_SHALLOW_COLOR = 3'd2,
        REG_SAND_COLOR    = 3'd3,
        REG_GRASS_COLOR   = 3'd4,
        REG_ROCK_COLOR    = 3'd5,
        REG_SNOW_COLOR    = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        BAND_DEEP,
        BAND_DEEP_SHALLOW,
        BAND_SHALLOW_SAND,
        BAND_SAND_GRASS,
        BAND_GRASS,
        BAND_GRASS_ROCK,
        BAND_ROCK,
        BAND_ROCK_SNOW,
        BAND_SNOW
    } band_t;

    typedef enum logic [1:0] {
        DIV_25,
        DIV_75,
        DIV_125
    } div_t;

    // Band stage -> divider stage
    typedef struct packed {
        band_t          band;
        div_t           div;
        logic [X_W-1:0] x;
    } frac_req_t;

    // Smoothstep stage -> blend stage
    typedef struct packed {
        band_t             band;
        logic [FRAC_W-1:0] weight;
    } blend_req_t;

    // ceil(2^31 / d); exact quotient for any numerator below 2^23
    function automatic logic [RECIP_W-1:0] recip(input div_t d);
        logic [RECIP_W-1:0] r;
        case (d)
            DIV_25:  r = 27'd85899346;
            DIV_75:  r = 27'd28633116;
            DIV_125: r = 27'd17179870;
            default: r = 27'd0;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/height_slope_color_ramp_top.sv
// Throughput: one item per cycle while the sink takes every output item; six register
//   stages (above/edge, band, divide, square, smoothstep, blend), each moves when the
//   stage after it has room.
// Reset (rst_n, async low) empties the pipeline and loads sea level 0 and the
//   default palette.
// Depends on hscr_pkg, hscr_cfg, hscr_band, hscr_smooth, hscr_blend.

module height_slope_color_ramp_top
    import hscr_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    localparam int PAL_W       = 3 * CHANNEL_BITS,
    localparam int CFG_W       = (PAL_W > HEIGHT_W) ? PAL_W : HEIGHT_W,
    localparam int OUT_TDATA_W = ((PAL_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // height_meters[15:0], slope_fraction[24:16]
    // Output items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // red, green, blue from bit 0 up
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [HEIGHT_W-1:0] sea_level;
    logic [PAL_W-1:0]    palette [NUM_COLORS];

    logic       band_valid;
    logic       band_ready;
    frac_req_t  band_req;
    logic       smooth_valid;
    logic       smooth_ready;
    blend_req_t smooth_req;
    logic [PAL_W-1:0] color;

    hscr_cfg #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sea_level (sea_level),
        .palette   (palette)
    );

    hscr_band u_band (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .height_meters  (s_axis_tdata[HEIGHT_W-1:0]),
        .slope_fraction (s_axis_tdata[HEIGHT_W +: SLOPE_W]),
        .sea_level      (sea_level),
        .out_valid      (band_valid),
        .out_ready      (band_ready),
        .out_req        (band_req)
    );

    hscr_smooth u_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (band_valid),
        .in_ready  (band_ready),
        .in_req    (band_req),
        .out_valid (smooth_valid),
        .out_ready (smooth_ready),
        .out_req   (smooth_req)
    );

    hscr_blend #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smooth_valid),
        .in_ready  (smooth_ready),
        .in_req    (smooth_req),
        .palette   (palette),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .color     (color)
    );

    assign m_axis_tdata = OUT_TDATA_W'(color);

    // An empty output register means every stage has room
    a_ready_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready
    ) else $error("input stalled while output register empty");

    // An item accepted with the sink ready throughout reaches the output register
    a_latency: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
        |=> m_axis_tvalid
    ) else $error("accepted item did not reach the output in time");

endmodule

>>> hw/rtl/hscr_cfg.sv
// hscr_cfg: configuration registers (sea level and six palette colors).
// Depends on hscr_pkg.

module hscr_cfg
    import hscr_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    localparam int PAL_W = 3 * CHANNEL_BITS,
    localparam int CFG_W = (PAL_W > HEIGHT_W) ? PAL_W : HEIGHT_W
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic [HEIGHT_W-1:0]  sea_level,
    output logic [PAL_W-1:0]     palette [NUM_COLORS]
);

    logic [HEIGHT_W-1:0] sea_level_reg;
    logic [PAL_W-1:0]    palette_reg [NUM_COLORS];

    assign cfg_ready = 1'b1;
    assign sea_level = sea_level_reg;
    assign palette   = palette_reg;

    // Register writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sea_level_reg <= '0;
            for (int i = 0; i < NUM_COLORS; i++)
            begin
                palette_reg[i] <= PAL_W'(COLOR_RESET[i]);
            end
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_SEA_LEVEL:     sea_level_reg <= cfg_data[HEIGHT_W-1:0];
                REG_DEEP_COLOR:    palette_reg[PAL_DEEP]    <= cfg_data[PAL_W-1:0];
                REG_SHALLOW_COLOR: palette_reg[PAL_SHALLOW] <= cfg_data[PAL_W-1:0];
                REG_SAND_COLOR:    palette_reg[PAL_SAND]    <= cfg_data[PAL_W-1:0];
                REG_GRASS_COLOR:   palette_reg[PAL_GRASS]   <= cfg_data[PAL_W-1:0];
                REG_ROCK_COLOR:    palette_reg[PAL_ROCK]    <= cfg_data[PAL_W-1:0];
                REG_SNOW_COLOR:    palette_reg[PAL_SNOW]    <= cfg_data[PAL_W-1:0];
                default:           ;
            endcase
        end
    end

endmodule

>>> hw/rtl/hscr_band.sv
// hscr_band: stages 1-2, height above sea, grass-to-rock edge, band select
// and the scaled numerator for the divider. Depends on hscr_pkg.

module hscr_band
    import hscr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [HEIGHT_W-1:0] height_meters,
    input  logic [SLOPE_W-1:0]  slope_fraction,
    input  logic [HEIGHT_W-1:0] sea_level,
    output logic                out_valid,
    input  logic                out_ready,
    output frac_req_t           out_req
);

    logic                      s1_valid_reg;
    logic signed [ABOVE_W-1:0] above_reg;
    logic [REDGE_W-1:0]        rock_edge_reg;
    logic                      s2_valid_reg;
    frac_req_t                 req_reg;

    logic                      en1;
    logic                      en2;
    logic signed [ABOVE_W-1:0] above_next;
    logic [REDGE_W-1:0]        slope_term;
    logic [REDGE_W-1:0]        rock_edge_next;
    logic signed [RDIFF_W-1:0] rock_diff;
    logic signed [ABOVE_W-1:0] rel;
    frac_req_t                 req_next;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // Stage 1: height above sea and grass-to-rock start
    assign above_next = $signed({height_meters[HEIGHT_W-1], height_meters})
                      - $signed({sea_level[HEIGHT_W-1], sea_level});
    assign slope_term     = REDGE_W'(slope_fraction) * REDGE_W'(SLOPE_GAIN);
    assign rock_edge_next = REDGE_W'(GRASS_ROCK_BASE_256) - slope_term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            above_reg     <= above_next;
            rock_edge_reg <= rock_edge_next;
        end
    end

    // Stage 2: band select and numerator
    assign rock_diff = $signed({above_reg[ABOVE_W-1], above_reg, 8'd0})
                     - $signed({7'd0, rock_edge_reg});

    always_comb
    begin
        rel      = '0;
        req_next = '{band: BAND_DEEP, div: DIV_25, x: '0};
        if (above_reg < EDGE_DEEP)
        begin
            req_next.band = BAND_DEEP;
        end
        else if (above_reg < EDGE_SEA)
        begin
            rel           = above_reg - EDGE_DEEP;
            req_next.band = BAND_DEEP_SHALLOW;
            req_next.x    = X_W'(rel[7:0]) << SHIFT_WATER;
        end
        else if (above_reg < EDGE_SAND)
        begin
            rel           = above_reg;
            req_next.band = BAND_SHALLOW_SAND;
            req_next.x    = X_W'(rel[7:0]) << SHIFT_WATER;
        end
        else if (above_reg < EDGE_GRASS)
        begin
            rel           = above_reg - EDGE_SAND;
            req_next.band = BAND_SAND_GRASS;
            req_next.x    = X_W'(rel[7:0]) << SHIFT_WATER;
        end
        else if (rock_diff < 0)
        begin
            req_next.band = BAND_GRASS;
        end
        else if (rock_diff < GRASS_ROCK_SPAN_256)
        begin
            req_next.band = BAND_GRASS_ROCK;
            req_next.div  = DIV_75;
            req_next.x    = X_W'(rock_diff[RNUM_W-1:0]) << SHIFT_ROCK;
        end
        else if (above_reg < EDGE_ROCK)
        begin
            req_next.band = BAND_ROCK;
        end
        else if (above_reg < EDGE_SNOW)
        begin
            rel           = above_reg - EDGE_ROCK;
            req_next.band = BAND_ROCK_SNOW;
            req_next.div  = DIV_125;
            req_next.x    = X_W'(rel[8:0]) << SHIFT_SNOW;
        end
        else
        begin
            req_next.band = BAND_SNOW;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            req_reg <= req_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_req   = req_reg;

endmodule

>>> hw/rtl/hscr_smooth.sv
// hscr_smooth: stages 3-5, reciprocal divide to t, then smoothstep
// s = t*t*(3-2t) in Q0.16. Depends on hscr_pkg.

module hscr_smooth
    import hscr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  frac_req_t  in_req,
    output logic       out_valid,
    input  logic       out_ready,
    output blend_req_t out_req
);

    logic              s3_valid_reg;
    logic              s4_valid_reg;
    logic              s5_valid_reg;
    band_t             band3_reg;
    band_t             band4_reg;
    band_t             band5_reg;
    logic [FRAC_W-1:0] t_reg;
    logic [FRAC_W-1:0] t2_reg;
    logic [KFAC_W-1:0] k_reg;
    logic [FRAC_W-1:0] s_reg;

    logic                     en3;
    logic                     en4;
    logic                     en5;
    logic [PROD_W-1:0]        quot_prod;
    logic [2*FRAC_W-1:0]      sq_prod;
    logic [FRAC_W+KFAC_W-1:0] s_prod;

    assign en5      = !s5_valid_reg || out_ready;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign in_ready = en3;

    // Stage 3: t = floor(x / d) via reciprocal multiply
    assign quot_prod = PROD_W'(in_req.x) * PROD_W'(recip(in_req.div));
    // Stage 4: t squared
    assign sq_prod   = (2*FRAC_W)'(t_reg) * (2*FRAC_W)'(t_reg);
    // Stage 5: t2 * (3 - 2t)
    assign s_prod    = (FRAC_W+KFAC_W)'(t2_reg) * (FRAC_W+KFAC_W)'(k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                s3_valid_reg <= in_valid;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            band3_reg <= in_req.band;
            t_reg     <= quot_prod[RECIP_SHIFT+FRAC_W-1:RECIP_SHIFT];
        end
        if (en4)
        begin
            band4_reg <= band3_reg;
            t2_reg    <= sq_prod[2*FRAC_W-1:FRAC_W];
            k_reg     <= SMOOTH_THREE - {1'b0, t_reg, 1'b0};
        end
        if (en5)
        begin
            band5_reg <= band4_reg;
            s_reg     <= s_prod[2*FRAC_W-1:FRAC_W];
        end
    end

    assign out_valid      = s5_valid_reg;
    assign out_req.band   = band5_reg;
    assign out_req.weight = s_reg;

endmodule

>>> hw/rtl/hscr_blend.sv
// hscr_blend: stage 6, picks the two palette colors of the band and blends
// each channel as a + (b - a)*s, truncated; holds the output item.
// Depends on hscr_pkg.

module hscr_blend
    import hscr_pkg::*;
#(
    parameter int CHANNEL_BITS = 8,
    localparam int PAL_W = 3 * CHANNEL_BITS
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  blend_req_t       in_req,
    input  logic [PAL_W-1:0] palette [NUM_COLORS],
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PAL_W-1:0] color
);

    localparam int MIX_W = CHANNEL_BITS + FRAC_W + 2;

    logic             out_valid_reg;
    logic [PAL_W-1:0] color_reg;

    logic             en6;
    logic [PAL_W-1:0] color_lo;
    logic [PAL_W-1:0] color_hi;
    logic [PAL_W-1:0] color_next;

    assign en6      = !out_valid_reg || out_ready;
    assign in_ready = en6;

    // Neighbor colors of the band
    always_comb
    begin
        case (in_req.band)
            BAND_DEEP:
            begin
                color_lo = palette[PAL_DEEP];
                color_hi = palette[PAL_DEEP];
            end
            BAND_DEEP_SHALLOW:
            begin
                color_lo = palette[PAL_DEEP];
                color_hi = palette[PAL_SHALLOW];
            end
            BAND_SHALLOW_SAND:
            begin
                color_lo = palette[PAL_SHALLOW];
                color_hi = palette[PAL_SAND];
            end
            BAND_SAND_GRASS:
            begin
                color_lo = palette[PAL_SAND];
                color_hi = palette[PAL_GRASS];
            end
            BAND_GRASS:
            begin
                color_lo = palette[PAL_GRASS];
                color_hi = palette[PAL_GRASS];
            end
            BAND_GRASS_ROCK:
            begin
                color_lo = palette[PAL_GRASS];
                color_hi = palette[PAL_ROCK];
            end
            BAND_ROCK:
            begin
                color_lo = palette[PAL_ROCK];
                color_hi = palette[PAL_ROCK];
            end
            BAND_ROCK_SNOW:
            begin
                color_lo = palette[PAL_ROCK];
                color_hi = palette[PAL_SNOW];
            end
            default:
            begin
                color_lo = palette[PAL_SNOW];
                color_hi = palette[PAL_SNOW];
            end
        endcase
    end

    // One blend lane per channel; lane 0 is red (top bits of a palette entry)
    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        localparam int SRC_LSB = (2 - j) * CHANNEL_BITS;
        localparam int DST_LSB = j * CHANNEL_BITS;

        logic [CHANNEL_BITS-1:0]       ch_lo;
        logic [CHANNEL_BITS-1:0]       ch_hi;
        logic signed [CHANNEL_BITS:0]  ch_diff;
        logic signed [MIX_W-1:0]       ch_mix;

        assign ch_lo   = color_lo[SRC_LSB +: CHANNEL_BITS];
        assign ch_hi   = color_hi[SRC_LSB +: CHANNEL_BITS];
        assign ch_diff = $signed({1'b0, ch_hi}) - $signed({1'b0, ch_lo});
        // both factors widened first so the product keeps every bit
        assign ch_mix  = $signed({2'b00, ch_lo, {FRAC_W{1'b0}}})
                       + MIX_W'(ch_diff) * MIX_W'($signed({1'b0, in_req.weight}));
        assign color_next[DST_LSB +: CHANNEL_BITS] =
            ch_mix[FRAC_W +: CHANNEL_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en6)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            color_reg <= color_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign color     = color_reg;

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for height_slope_color_ramp_top. A directed table
// of band edges runs first, then random heights and slopes under several palettes.
// Depends on hscr_pkg and the RTL of the color ramp.

module tb_top;
    import hscr_pkg::*;

    localparam int PIPE_LATENCY   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SET  = 76;
    localparam int NUM_PROBES     = 26;
    localparam int CFG_DATA_W     = 24;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 3'd7;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [15:0] hgt;
        logic [8:0]  slp;
        logic        typed;   // rgb holds the expected color
        logic [23:0] rgb;
    } probe_t;

    typedef enum int {
        SINK_OPEN,
        SINK_BUSY_LIGHT,
        SINK_BUSY_HEAVY,
        SINK_PERIODIC
    } sink_mode_t;

    // Band edges, extremes and slope corners
    localparam probe_t PROBES [NUM_PROBES] = '{
        '{16'h8000,      9'd0,   1'b1, 24'h102A60},
        '{16'h7FFF,      9'd0,   1'b1, 24'hF0F0F5},
        '{-16'sd201,     9'd511, 1'b1, 24'h102A60},
        '{-16'sd200,     9'd0,   1'b1, 24'h102A60},
        '{-16'sd100,     9'd0,   1'b0, 24'h0},
        '{-16'sd1,       9'd0,   1'b0, 24'h0},
        '{16'd0,         9'd0,   1'b1, 24'h2A6AA0},
        '{16'd100,       9'd0,   1'b0, 24'h0},
        '{16'd199,       9'd0,   1'b0, 24'h0},
        '{16'd200,       9'd0,   1'b1, 24'hC8B478},
        '{16'd300,       9'd0,   1'b0, 24'h0},
        '{16'd400,       9'd0,   1'b1, 24'h3C7828},
        '{16'd1499,      9'd0,   1'b1, 24'h3C7828},
        '{16'd1500,      9'd0,   1'b1, 24'h3C7828},
        '{16'd1650,      9'd0,   1'b0, 24'h0},
        '{16'd1800,      9'd0,   1'b1, 24'h6E6460},
        '{16'd1000,      9'd256, 1'b1, 24'h3C7828},
        '{16'd1299,      9'd256, 1'b0, 24'h0},
        '{16'd1300,      9'd256, 1'b1, 24'h6E6460},
        '{16'd501,       9'd511, 1'b1, 24'h3C7828},
        '{16'd502,       9'd511, 1'b0, 24'h0},
        '{16'd3999,      9'd100, 1'b1, 24'h6E6460},
        '{16'd4000,      9'd0,   1'b1, 24'h6E6460},
        '{16'd4250,      9'd300, 1'b0, 24'h0},
        '{16'd4499,      9'd0,   1'b0, 24'h0},
        '{16'd4500,      9'd0,   1'b1, 24'hF0F0F5}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Side info that travels with each input item
    logic                  probe_typed = 1'b0;
    logic [23:0]           probe_rgb = '0;

    // Predictor copy of the registers
    logic signed [15:0]    sea_lvl = '0;
    logic [23:0]           pal [NUM_COLORS] = '{
        24'h102A60, 24'h2A6AA0, 24'hC8B478, 24'h3C7828, 24'h6E6460, 24'hF0F0F5
    };

    color_t                pending_colors [$];
    int                    items_sent = 0;
    int                    results_seen = 0;
    int                    errors = 0;
    int                    burst_left = 0;
    int                    quiet_cycles = 0;
    int                    cyc = 0;
    sink_mode_t            sink_mode = SINK_OPEN;
    int                    sink_left = 0;

    height_slope_color_ramp_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // floor(num*65536/den), num clamped into [0,den)
    function automatic longint band_pos(input longint num, input longint den);
        longint n;
        n = num;
        if (n < 0)
            n = 0;
        if (n >= den)
            n = den - 1;
        return (n << 16) / den;
    endfunction

    // t*t*(3-2t) in Q0.16
    function automatic longint smooth_weight(input longint t);
        longint t2;
        t2 = (t * t) >> 16;
        return (t2 * (196608 - 2 * t)) >> 16;
    endfunction

    // Expected color for one height/slope pair under the current registers
    function automatic color_t ramp_color(input logic [15:0] hgt, input logic [8:0] slp);
        longint a, a256, r256, re256, w, ca, cb, v;
        int     lo, hi, sh, j;
        color_t c;
        a     = longint'($signed(hgt)) - longint'(sea_lvl);
        a256  = a * 256;
        r256  = 384000 - longint'(slp) * 500;
        re256 = r256 + 76800;
        w     = 0;
        if (a < -200)
        begin
            lo = PAL_DEEP; hi = PAL_DEEP;
        end
        else if (a < 0)
        begin
            lo = PAL_DEEP; hi = PAL_SHALLOW; w = smooth_weight(band_pos(a + 200, 200));
        end
        else if (a < 200)
        begin
            lo = PAL_SHALLOW; hi = PAL_SAND; w = smooth_weight(band_pos(a, 200));
        end
        else if (a < 400)
        begin
            lo = PAL_SAND; hi = PAL_GRASS; w = smooth_weight(band_pos(a - 200, 200));
        end
        else if (a256 < r256)
        begin
            lo = PAL_GRASS; hi = PAL_GRASS;
        end
        else if (a256 < re256)
        begin
            lo = PAL_GRASS; hi = PAL_ROCK; w = smooth_weight(band_pos(a256 - r256, 76800));
        end
        else if (a < 4000)
        begin
            lo = PAL_ROCK; hi = PAL_ROCK;
        end
        else if (a < 4500)
        begin
            lo = PAL_ROCK; hi = PAL_SNOW; w = smooth_weight(band_pos(a - 4000, 500));
        end
        else
        begin
            lo = PAL_SNOW; hi = PAL_SNOW;
        end
        for (j = 0; j < 3; j++)
        begin
            sh = (2 - j) * 8;
            ca = longint'((pal[lo] >> sh) & 24'hFF);
            cb = longint'((pal[hi] >> sh) & 24'hFF);
            v  = (ca * (65536 - w) + cb * w) >> 16;
            case (j)
                0:       c.red   = v[7:0];
                1:       c.green = v[7:0];
                default: c.blue  = v[7:0];
            endcase
        end
        return c;
    endfunction

    task automatic check_channel(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    // Monitor: check results, record expectations and register writes
    always @(posedge clk)
    begin
        color_t want;
        color_t typed_col;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_colors.size() == 0)
                begin
                    $error("result %h with no item waiting", m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = pending_colors.pop_front();
                    check_channel("red",   want.red,   m_axis_tdata[7:0]);
                    check_channel("green", want.green, m_axis_tdata[15:8]);
                    check_channel("blue",  want.blue,  m_axis_tdata[23:16]);
                end
                results_seen++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (probe_typed)
                begin
                    typed_col.red   = probe_rgb[23:16];
                    typed_col.green = probe_rgb[15:8];
                    typed_col.blue  = probe_rgb[7:0];
                    pending_colors.push_back(typed_col);
                end
                else
                    pending_colors.push_back(ramp_color(s_axis_tdata[15:0],
                                                        s_axis_tdata[24:16]));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SEA_LEVEL:
                        sea_lvl = cfg_data[15:0];
                    REG_DEEP_COLOR, REG_SHALLOW_COLOR, REG_SAND_COLOR,
                    REG_GRASS_COLOR, REG_ROCK_COLOR, REG_SNOW_COLOR:
                        pal[cfg_index - 3'd1] = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Output backpressure: a random sink mode, redrawn when its run ends
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (sink_left == 0)
        begin
            sink_mode <= sink_mode_t'($urandom_range(0, 3));
            sink_left <= $urandom_range(16, 96);
        end
        else
            sink_left <= sink_left - 1;
        case (sink_mode)
            SINK_OPEN:       m_axis_tready <= 1'b1;
            SINK_BUSY_LIGHT: m_axis_tready <= ($urandom_range(0, 3) != 0);
            SINK_BUSY_HEAVY: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:         m_axis_tready <= cyc[2];
        endcase
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Present one item, wait for it to be taken, then maybe open a gap
    task automatic send_item(input logic [15:0] hgt, input logic [8:0] slp,
                             input logic typed, input logic [23:0] rgb);
        s_axis_tdata  <= {7'd0, slp, hgt};
        probe_typed   <= typed;
        probe_rgb     <= rgb;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 96)
                                                      : $urandom_range(0, 16);
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Hold off input until every result is back and the pipe is empty
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (results_seen != items_sent)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        int          i;
        int          n;
        int          set_no;
        int          sea;
        int          target;
        int          grass_rock_m;
        logic [23:0] colors [NUM_COLORS];
        logic [15:0] hgt;
        logic [8:0]  slp;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset registers
        for (i = 0; i < NUM_PROBES; i++)
            send_item(PROBES[i].hgt, PROBES[i].slp, PROBES[i].typed, PROBES[i].rgb);

        for (set_no = 1; set_no <= 5; set_no++)
        begin
            settle();
            case (set_no)
                1:
                begin
                    sea = -32768;
                    for (i = 0; i < NUM_COLORS; i++)
                        colors[i] = (i % 2 != 0) ? 24'hFFFFFF : 24'h000000;
                end
                2:
                begin
                    sea = 32767;
                    for (i = 0; i < NUM_COLORS; i++)
                        colors[i] = (i % 2 != 0) ? 24'h000000 : 24'hFFFFFF;
                end
                3:
                begin
                    sea = 0;
                    for (i = 0; i < NUM_COLORS; i++)
                        colors[i] = 24'($urandom());
                end
                4:
                begin
                    sea = $urandom_range(0, 4000) - 2000;
                    for (i = 0; i < NUM_COLORS; i++)
                        colors[i] = 24'($urandom());
                end
                default:
                begin
                    sea = $signed(16'($urandom()));
                    for (i = 0; i < NUM_COLORS; i++)
                        colors[i] = 24'($urandom());
                end
            endcase
            // upper data bits are junk for the 16-bit sea level
            write_reg(REG_SEA_LEVEL, {8'($urandom()), 16'(sea)});
            for (i = 0; i < NUM_COLORS; i++)
                write_reg(CFG_IDX_W'(REG_DEEP_COLOR + i), colors[i]);
            write_reg(REG_UNUSED_IDX, 24'($urandom()));
            cfg_valid <= 1'b0;

            for (n = 0; n < ITEMS_PER_SET; n++)
            begin
                // slope: mostly in range, some above 1.0, some corners
                case ($urandom_range(0, 15))
                    0:       slp = 9'd0;
                    1:       slp = 9'd256;
                    2:       slp = 9'd511;
                    3, 4:    slp = 9'($urandom_range(257, 511));
                    default: slp = 9'($urandom_range(0, 256));
                endcase
                grass_rock_m = (384000 - int'(slp) * 500) / 256;
                case ($urandom_range(0, 9))
                    6, 7:
                        hgt = 16'($urandom());
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0:       hgt = 16'h8000;
                            1:       hgt = 16'h7FFF;
                            2:       hgt = 16'h0000;
                            default: hgt = 16'hFFFF;
                        endcase
                    end
                    9:
                        hgt = 16'(sea + $urandom_range(0, 5400) - 400);
                    default:
                    begin
                        // near a band edge, relative to sea level
                        case ($urandom_range(0, 7))
                            0:       target = -200;
                            1:       target = 0;
                            2:       target = 200;
                            3:       target = 400;
                            4:       target = grass_rock_m;
                            5:       target = grass_rock_m + 300;
                            6:       target = 4000;
                            default: target = 4500;
                        endcase
                        hgt = 16'(sea + target + $urandom_range(0, 16) - 8);
                    end
                endcase
                send_item(hgt, slp, 1'b0, 24'h0);
            end
        end

        settle();
        repeat (PIPE_LATENCY * 4)
            @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_colors.size());
            errors++;
        end
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
